// File: rtl/encoder_index_drift_corrector_macros.svh
// Assertion macros shared by the drift corrector RTL
`ifndef ENCODER_INDEX_DRIFT_CORRECTOR_MACROS_SVH
`define ENCODER_INDEX_DRIFT_CORRECTOR_MACROS_SVH

// Property must hold in every cycle out of reset
`define EIDC_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define EIDC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/eidc_pkg.sv
// Types and constants of the encoder index drift corrector
`default_nettype none

package eidc_pkg;

    localparam int IN_W       = 32;
    localparam int OUT_W      = 136;
    localparam int CPR_W      = 21;
    localparam int REM_W      = 21;
    localparam int DVD_W      = 32;
    localparam int STEP_W     = 6;
    localparam int ANG_W      = 16;

    localparam logic [STEP_W-1:0] MOD_STEPS   = 6'd32;
    localparam logic [STEP_W-1:0] ANGLE_STEPS = 6'd16;

    localparam logic [3:0] POLE_DIVISOR = 4'd12;

    localparam logic [20:0] CPR_RESET  = 21'd8000;
    localparam logic [6:0]  PP_RESET   = 7'd8;
    localparam logic [9:0]  JMIN_RESET = 10'd10;
    localparam logic [9:0]  TOL_RESET  = 10'd40;
    localparam logic [3:0]  REVS_RESET = 4'd5;

    typedef enum logic [2:0] {
        REG_COUNTS_PER_REV     = 3'd0,
        REG_POLE_PAIRS         = 3'd1,
        REG_INDEX_JUMP_MIN     = 3'd2,
        REG_REV_TOLERANCE      = 3'd3,
        REG_MISSING_INDEX_REVS = 3'd4,
        REG_TEST_OFFSET        = 3'd5
    } cfg_idx_t;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_ACC  = 8'b0000_0010,
        S_MAXQ = 8'b0000_0100,
        S_MAXA = 8'b0000_1000,
        S_MOD  = 8'b0001_0000,
        S_FBA  = 8'b0010_0000,
        S_UPD  = 8'b0100_0000,
        S_OUT  = 8'b1000_0000
    } state_t;

    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
    } div_req_t;

    typedef struct packed {
        logic done;
        logic busy;
    } div_rsp_t;

endpackage

`default_nettype wire

// File: rtl/eidc_divider.sv
// Shared restoring divider, one quotient bit per cycle
`default_nettype none

module eidc_divider
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire eidc_pkg::div_req_t         req,
    input  wire logic [eidc_pkg::DVD_W-1:0] dividend,
    input  wire logic [eidc_pkg::REM_W-1:0] rem_init,
    input  wire logic [eidc_pkg::REM_W-1:0] divisor,
    output eidc_pkg::div_rsp_t              rsp,
    output logic [eidc_pkg::DVD_W-1:0]      quot,
    output logic [eidc_pkg::REM_W-1:0]      rem
);

    logic [eidc_pkg::DVD_W-1:0]  dvd_reg;
    logic [eidc_pkg::DVD_W-1:0]  quot_reg;
    logic [eidc_pkg::REM_W-1:0]  rem_reg;
    logic [eidc_pkg::REM_W-1:0]  dsr_reg;
    logic [eidc_pkg::STEP_W-1:0] cnt_reg;
    logic                        busy_reg;
    logic                        done_reg;

    logic [eidc_pkg::REM_W:0]    trial;
    logic [eidc_pkg::REM_W:0]    diff;
    logic                        ge;
    logic [eidc_pkg::REM_W-1:0]  rem_next;

    // bring down the next dividend bit and subtract where it fits
    assign trial    = {rem_reg, dvd_reg[eidc_pkg::DVD_W-1]};
    assign ge       = trial >= {1'b0, dsr_reg};
    assign diff     = trial - {1'b0, dsr_reg};
    assign rem_next = ge ? diff[eidc_pkg::REM_W-1:0] : trial[eidc_pkg::REM_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.steps;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == 1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dvd_reg  <= dividend;
            rem_reg  <= rem_init;
            dsr_reg  <= divisor;
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg  <= {dvd_reg[eidc_pkg::DVD_W-2:0], 1'b0};
            rem_reg  <= rem_next;
            quot_reg <= {quot_reg[eidc_pkg::DVD_W-2:0], ge};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.busy = busy_reg;
    assign quot     = quot_reg;
    assign rem      = rem_reg;

endmodule

`default_nettype wire

// File: rtl/encoder_index_drift_corrector.sv
// Top level of the encoder index drift corrector
`default_nettype none

// Extends raw 16-bit quadrature and index-capture samples to 32-bit counts,
// adds the test offset and the drift correction, maps the index latch to a
// 16-bit angle and nudges the correction by one count towards the angle fixed
// by the first real index. Each input transaction yields one output
// transaction. An item takes four passes of a single shared bit-serial
// divider (32 + 16 + 32 + 16 steps for the mismatch threshold, its angle,
// the latch modulo counts_per_rev and the latch angle) plus the sequencer
// states. The input side is ready only while the sequencer is idle;
// a finished result waits in the output register, so the next input may be
// taken before it is collected. Configuration writes are taken at any time
// but must only be made while the block is idle.

module encoder_index_drift_corrector
#(
    parameter int HISTORY_DEPTH = 5
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // quad_counter_raw[15:0], index_capture_raw[31:16]
    input  wire logic [eidc_pkg::IN_W-1:0]     s_tdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // position_count[31:0], corrected_count[63:32], target_angle[79:64],
    // latched_angle[95:80], drift_correction[127:96], index_locked[128],
    // mismatch_alarm[129], missing_index_alarm[130], zero[135:131]
    output logic [eidc_pkg::OUT_W-1:0]         m_tdata,
    input  wire logic                          cfg_we,
    input  wire logic [2:0]                    cfg_index,
    input  wire logic [31:0]                   cfg_data
);

    `include "encoder_index_drift_corrector_macros.svh"

    // configuration
    logic [20:0] cpr_reg;
    logic [6:0]  pp_reg;
    logic [9:0]  jmin_reg;
    logic [9:0]  tol_reg;
    logic [3:0]  revs_reg;
    logic [31:0] offs_reg;

    // tracking state
    eidc_pkg::state_t state_reg, state_next;
    logic [15:0] q_raw_reg, i_raw_reg, last_q_reg, last_i_reg;
    logic [31:0] quad_acc_reg, idx_acc_reg, corr_reg, cal_reg, pl_reg;
    logic [31:0] count_reg, latch_reg, jump_reg;
    logic        locked_reg, mism_reg, missing_reg;
    logic [15:0] ref_reg, latched_reg, maxerr_reg, fb_reg;
    logic [15:0] hist_reg [HISTORY_DEPTH];

    // output register
    logic                        m_tvalid_reg;
    logic [eidc_pkg::OUT_W-1:0]  m_tdata_reg;

    // divider
    eidc_pkg::div_req_t           div_req;
    eidc_pkg::div_rsp_t           div_rsp;
    logic [eidc_pkg::DVD_W-1:0]   div_dvd, div_quot;
    logic [eidc_pkg::REM_W-1:0]   div_init, div_dsr, div_rem;

    logic [20:0] cpr_eff;
    logic [6:0]  pp_eff;
    logic [10:0] pdiv;

    logic [15:0] dq, di;
    logic [31:0] qacc_new, iacc_new, count_new, latch_new, cal_eff, pl_eff;
    logic [31:0] lj, jump_new, latch_abs;
    logic [20:0] r_fix, r_neg;

    logic        real_index;
    logic [15:0] err16;
    logic [32:0] dev, dev_abs;
    logic        nudge;
    logic [15:0] hist_new [HISTORY_DEPTH];
    logic        all_bad;
    logic [31:0] cdiff, gap;
    logic [24:0] gap_limit;
    logic        out_load;
    logic        in_accept;

    function automatic logic [16:0] ang_dist(input logic [15:0] a, input logic [15:0] r);
        logic [15:0] d;
        d = a - r;
        ang_dist = d[15] ? (17'h10000 - {1'b0, d}) : {1'b0, d};
    endfunction

    function automatic logic [31:0] mag32(input logic [31:0] v);
        mag32 = v[31] ? (32'd0 - v) : v;
    endfunction

    assign cpr_eff = (cpr_reg == '0) ? 21'd1 : cpr_reg;
    assign pp_eff  = (pp_reg == '0) ? 7'd1 : pp_reg;
    assign pdiv    = pp_eff * eidc_pkg::POLE_DIVISOR;

    // extend the raw counters by their signed 16-bit steps
    assign dq        = q_raw_reg - last_q_reg;
    assign di        = i_raw_reg - last_i_reg;
    assign qacc_new  = quad_acc_reg + {{16{dq[15]}}, dq};
    assign iacc_new  = idx_acc_reg + {{16{di[15]}}, di};
    assign count_new = qacc_new + offs_reg + corr_reg;
    assign latch_new = iacc_new + offs_reg + corr_reg;
    assign cal_eff   = (cal_reg == '0) ? count_new : cal_reg;
    assign pl_eff    = (pl_reg == '0) ? latch_new : pl_reg;
    assign lj        = latch_new - pl_eff;
    assign jump_new  = mag32(lj);

    // non-negative remainder of a negative latch
    assign latch_abs = mag32(latch_reg);
    assign r_neg     = cpr_eff - div_rem;
    assign r_fix     = (latch_reg[31] && div_rem != '0) ? r_neg : div_rem;

    // sequencer: hand each division to the shared unit in turn
    always_comb
    begin
        state_next    = state_reg;
        div_req.start = 1'b0;
        div_req.steps = eidc_pkg::MOD_STEPS;
        div_dvd       = '0;
        div_init      = '0;
        div_dsr       = cpr_eff;
        unique case (state_reg)
            eidc_pkg::S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = eidc_pkg::S_ACC;
                end
            end
            eidc_pkg::S_ACC:
            begin
                state_next    = eidc_pkg::S_MAXQ;
                div_req.start = 1'b1;
                div_dvd       = {11'd0, cpr_eff};
                div_dsr       = {10'd0, pdiv};
            end
            eidc_pkg::S_MAXQ:
            begin
                if (div_rsp.done)
                begin
                    state_next    = eidc_pkg::S_MAXA;
                    div_req.start = 1'b1;
                    div_req.steps = eidc_pkg::ANGLE_STEPS;
                    div_init      = div_quot[eidc_pkg::REM_W-1:0];
                end
            end
            eidc_pkg::S_MAXA:
            begin
                if (div_rsp.done)
                begin
                    state_next    = eidc_pkg::S_MOD;
                    div_req.start = 1'b1;
                    div_dvd       = latch_abs;
                end
            end
            eidc_pkg::S_MOD:
            begin
                if (div_rsp.done)
                begin
                    state_next    = eidc_pkg::S_FBA;
                    div_req.start = 1'b1;
                    div_req.steps = eidc_pkg::ANGLE_STEPS;
                    div_init      = r_fix;
                end
            end
            eidc_pkg::S_FBA:
            begin
                if (div_rsp.done)
                begin
                    state_next = eidc_pkg::S_UPD;
                end
            end
            eidc_pkg::S_UPD:
            begin
                state_next = eidc_pkg::S_OUT;
            end
            eidc_pkg::S_OUT:
            begin
                if (out_load)
                begin
                    state_next = eidc_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = eidc_pkg::S_IDLE;
            end
        endcase
    end

    eidc_divider u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .dividend (div_dvd),
        .rem_init (div_init),
        .divisor  (div_dsr),
        .rsp      (div_rsp),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    // update decisions
    assign real_index = jump_reg > {22'd0, jmin_reg};
    assign err16      = fb_reg - ref_reg;
    assign dev        = {1'b0, jump_reg} - {12'd0, cpr_eff};
    assign dev_abs    = dev[32] ? (33'd0 - dev) : dev;
    assign nudge      = (err16 != '0) && (dev_abs <= {23'd0, tol_reg});

    always_comb
    begin
        hist_new[0] = fb_reg;
        for (int i = 1; i < HISTORY_DEPTH; i++)
        begin
            hist_new[i] = hist_reg[i-1];
        end
        all_bad = 1'b1;
        for (int i = 0; i < HISTORY_DEPTH; i++)
        begin
            if (!(ang_dist(hist_new[i], ref_reg) > {1'b0, maxerr_reg}))
            begin
                all_bad = 1'b0;
            end
        end
    end

    // a real index resets the reference count, so the gap is then zero
    assign cdiff     = count_reg - cal_reg;
    assign gap       = real_index ? 32'd0 : mag32(cdiff);
    assign gap_limit = cpr_eff * revs_reg;

    assign in_accept = s_tvalid && s_tready;
    assign out_load  = (state_reg == eidc_pkg::S_OUT) && (!m_tvalid_reg || m_tready);

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cpr_reg  <= eidc_pkg::CPR_RESET;
            pp_reg   <= eidc_pkg::PP_RESET;
            jmin_reg <= eidc_pkg::JMIN_RESET;
            tol_reg  <= eidc_pkg::TOL_RESET;
            revs_reg <= eidc_pkg::REVS_RESET;
            offs_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                eidc_pkg::REG_COUNTS_PER_REV:     cpr_reg  <= cfg_data[20:0];
                eidc_pkg::REG_POLE_PAIRS:         pp_reg   <= cfg_data[6:0];
                eidc_pkg::REG_INDEX_JUMP_MIN:     jmin_reg <= cfg_data[9:0];
                eidc_pkg::REG_REV_TOLERANCE:      tol_reg  <= cfg_data[9:0];
                eidc_pkg::REG_MISSING_INDEX_REVS: revs_reg <= cfg_data[3:0];
                eidc_pkg::REG_TEST_OFFSET:        offs_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // tracking state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= eidc_pkg::S_IDLE;
            last_q_reg   <= '0;
            last_i_reg   <= '0;
            quad_acc_reg <= '0;
            idx_acc_reg  <= '0;
            corr_reg     <= '0;
            cal_reg      <= '0;
            pl_reg       <= '0;
            locked_reg   <= 1'b0;
            ref_reg      <= '0;
            latched_reg  <= '0;
            mism_reg     <= 1'b0;
            missing_reg  <= 1'b0;
            for (int i = 0; i < HISTORY_DEPTH; i++)
            begin
                hist_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == eidc_pkg::S_ACC)
            begin
                last_q_reg   <= q_raw_reg;
                last_i_reg   <= i_raw_reg;
                quad_acc_reg <= qacc_new;
                idx_acc_reg  <= iacc_new;
                cal_reg      <= cal_eff;
                pl_reg       <= pl_eff;
            end
            if (state_reg == eidc_pkg::S_UPD)
            begin
                missing_reg <= gap > {7'd0, gap_limit};
                if (!locked_reg)
                begin
                    if (real_index)
                    begin
                        ref_reg    <= fb_reg;
                        cal_reg    <= count_reg;
                        pl_reg     <= latch_reg;
                        locked_reg <= 1'b1;
                    end
                    else
                    begin
                        ref_reg <= '0;
                    end
                end
                else if (real_index)
                begin
                    // step one count against the sign of the angle error
                    if (nudge)
                    begin
                        corr_reg <= err16[15] ? (corr_reg + 32'd1) : (corr_reg - 32'd1);
                    end
                    latched_reg <= fb_reg;
                    for (int i = 0; i < HISTORY_DEPTH; i++)
                    begin
                        hist_reg[i] <= hist_new[i];
                    end
                    mism_reg <= all_bad;
                    cal_reg  <= count_reg;
                    pl_reg   <= latch_reg;
                end
            end
        end
    end

    // per-item working registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            q_raw_reg <= s_tdata[15:0];
            i_raw_reg <= s_tdata[31:16];
        end
        if (state_reg == eidc_pkg::S_ACC)
        begin
            count_reg <= count_new;
            latch_reg <= latch_new;
            jump_reg  <= jump_new;
        end
        if (state_reg == eidc_pkg::S_MAXA && div_rsp.done)
        begin
            maxerr_reg <= div_quot[15:0];
        end
        if (state_reg == eidc_pkg::S_FBA && div_rsp.done)
        begin
            fb_reg <= div_quot[15:0];
        end
    end

    // output register: hold the result until it is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            m_tdata_reg <= {5'd0, missing_reg, mism_reg, locked_reg, corr_reg,
                            latched_reg, ref_reg, count_reg, quad_acc_reg};
        end
    end

    assign s_tready = (state_reg == eidc_pkg::S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `EIDC_ASSERT_ALWAYS(a_div_free, !div_req.start || !div_rsp.busy,
        "divider started while busy")
    `EIDC_ASSERT_NEXT(a_lock_holds, locked_reg, locked_reg,
        "index lock dropped")
    `EIDC_ASSERT_NEXT(a_accept_leaves_idle, in_accept, state_reg == eidc_pkg::S_ACC,
        "accepted transaction not started")
    `EIDC_ASSERT_NEXT(a_load_shows, out_load, m_tvalid,
        "loaded result not presented")

endmodule

`default_nettype wire

// File: tb/tb_encoder_index_drift_corrector.sv
// Self-checking bench for the encoder index drift corrector
`timescale 1ns / 1ps
`default_nettype none

module tb_encoder_index_drift_corrector;

    localparam int HIST = 5;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [15:0] index_raw;
        logic [15:0] quad_raw;
    } sample_t;

    typedef struct packed {
        logic [4:0]  pad;
        logic        missing_alarm;
        logic        mismatch_alarm;
        logic        locked;
        logic [31:0] drift;
        logic [15:0] latched;
        logic [15:0] target;
        logic [31:0] corrected;
        logic [31:0] position;
    } posn_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [31:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [135:0] m_tdata;
    logic cfg_we = 1'b0;
    logic [2:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;

    always #4 clk = ~clk;

    encoder_index_drift_corrector i_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Predictor configuration and state
    logic [20:0] cpr;
    logic [6:0]  poles;
    logic [9:0]  jump_min;
    logic [9:0]  rev_tol;
    logic [3:0]  miss_revs;
    logic [31:0] offset;
    logic [15:0] prev_quad, prev_index, ref_ang, latch_ang;
    logic [31:0] quad_sum, index_sum, correction, count_at_index, last_latch;
    logic        locked, mismatch_hold;
    logic [15:0] history [HIST];

    sample_t pending_samples[$];
    posn_t   expected_posns[$];
    int      failures = 0;
    bit      rx_hold = 0;
    bit      no_idle = 0;
    int      idle_cycles = 0;

    logic [15:0] prev_quad_shadow = '0, prev_index_shadow = '0;

    function automatic logic [31:0] magnitude(input logic [31:0] v);
        return v[31] ? 32'd0 - v : v;
    endfunction

    function automatic logic [15:0] angle_of(input longint v, input longint c);
        longint r;
        r = v % c;
        if (r < 0)
            r += c;
        return 16'((r * 65536) / c);
    endfunction

    function automatic int angle_diff(input logic [15:0] a, input logic [15:0] b);
        logic [15:0] d;
        d = a - b;
        return d[15] ? int'(d) - 65536 : int'(d);
    endfunction

    // Advance the predictor by one sample and queue the expected position
    task automatic predict_position(input sample_t smp);
        posn_t  p;
        logic [31:0] count, latch, jump, gap;
        logic [15:0] thresh, fb;
        longint c, dev;
        int err, e;
        bit all_bad;
        c = (cpr == 0) ? 1 : longint'(cpr);
        quad_sum = quad_sum + {{16{1'(16'(smp.quad_raw - prev_quad) >> 15)}},
                               16'(smp.quad_raw - prev_quad)};
        prev_quad = smp.quad_raw;
        index_sum = index_sum + {{16{1'(16'(smp.index_raw - prev_index) >> 15)}},
                                 16'(smp.index_raw - prev_index)};
        prev_index = smp.index_raw;
        count = quad_sum + offset + correction;
        latch = index_sum + offset + correction;
        if (count_at_index == 0)
            count_at_index = count;
        if (last_latch == 0)
            last_latch = latch;
        jump = magnitude(latch - last_latch);
        thresh = angle_of(c / (((poles == 0) ? 1 : longint'(poles)) * 12), c);
        if (!locked)
        begin
            if (jump > jump_min)
            begin
                ref_ang = angle_of(longint'(signed'(latch)), c);
                count_at_index = count;
                last_latch = latch;
                locked = 1'b1;
            end
            else
                ref_ang = '0;
        end
        else if (jump > jump_min)
        begin
            fb = angle_of(longint'(signed'(latch)), c);
            err = angle_diff(fb, ref_ang);
            dev = longint'(jump) - c;
            if (dev < 0)
                dev = -dev;
            if (err != 0 && dev <= longint'(rev_tol))
                correction = correction + ((err > 0) ? 32'hFFFF_FFFF : 32'd1);
            latch_ang = fb;
            for (int i = HIST - 1; i > 0; i--)
                history[i] = history[i-1];
            history[0] = fb;
            all_bad = 1;
            for (int i = 0; i < HIST; i++)
            begin
                e = angle_diff(history[i], ref_ang);
                if (e < 0)
                    e = -e;
                if (!(e > int'(thresh)))
                    all_bad = 0;
            end
            mismatch_hold = all_bad;
            count_at_index = count;
            last_latch = latch;
        end
        gap = magnitude(count - count_at_index);
        p = '0;
        p.position = quad_sum;
        p.corrected = count;
        p.target = ref_ang;
        p.latched = latch_ang;
        p.drift = correction;
        p.locked = locked;
        p.mismatch_alarm = mismatch_hold;
        p.missing_alarm = longint'(gap) > ((c * miss_revs) & 64'hFFFF_FFFF);
        expected_posns.push_back(p);
    endtask

    // Driver: offer pending samples, predicting on each accepted transaction;
    // hold an offered transaction unchanged until it is taken
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                predict_position(sample_t'(s_tdata));
                void'(pending_samples.pop_front());
            end
            if (!s_tvalid || s_tready)
            begin
                if (pending_samples.size() > 0 &&
                    (no_idle || $urandom_range(99) >= 22))
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pending_samples[0];
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver readiness, with idling and the long hold-off
    always @(posedge clk)
    begin
        if (rst_n)
            m_tready <= !rx_hold && (no_idle || $urandom_range(99) >= 22);
    end

    // Monitor: compare each output transaction with the oldest prediction
    always @(posedge clk)
    begin
        posn_t got, want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = posn_t'(m_tdata);
            if (expected_posns.size() == 0)
            begin
                $display("%0t: unexpected output %h", $time, m_tdata);
                failures++;
            end
            else
            begin
                want = expected_posns.pop_front();
                if (got != want)
                begin
                    $display("%0t: expected %h actual %h", $time, want, got);
                    failures++;
                end
            end
        end
    end

    // Watchdog on cycles with no transaction on either side
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            idle_cycles <= 0;
        else if (!rx_hold)
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    task automatic write_reg(input eidc_pkg::cfg_idx_t idx, input logic [31:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            eidc_pkg::REG_COUNTS_PER_REV:     cpr = val[20:0];
            eidc_pkg::REG_POLE_PAIRS:         poles = val[6:0];
            eidc_pkg::REG_INDEX_JUMP_MIN:     jump_min = val[9:0];
            eidc_pkg::REG_REV_TOLERANCE:      rev_tol = val[9:0];
            eidc_pkg::REG_MISSING_INDEX_REVS: miss_revs = val[3:0];
            default:                          offset = val;
        endcase
    endtask

    // Hold until every queued sample is consumed and every result collected
    task automatic drain();
        while (pending_samples.size() != 0 || expected_posns.size() != 0)
            @(posedge clk);
        repeat (150) @(posedge clk);
    endtask

    // Encoder motion: quad advances, index steps about a rev or jumps at random
    task automatic queue_motion(input int n, input int rev);
        logic [15:0] q, ix;
        q = prev_quad_shadow;
        ix = prev_index_shadow;
        for (int k = 0; k < n; k++)
        begin
            q = q + 16'($urandom_range(rev / 4 + 1));
            if ($urandom_range(3) == 0)
                ix = ix + 16'(rev + $urandom_range(8) - 4);
            else if ($urandom_range(9) == 0)
                ix = 16'($urandom);
            pending_samples.push_back({ix, q});
        end
        prev_quad_shadow = q;
        prev_index_shadow = ix;
    endtask

    initial
    begin
        int rev;
        cpr = eidc_pkg::CPR_RESET; poles = eidc_pkg::PP_RESET;
        jump_min = eidc_pkg::JMIN_RESET;
        rev_tol = eidc_pkg::TOL_RESET; miss_revs = eidc_pkg::REVS_RESET; offset = '0;
        prev_quad = '0; prev_index = '0; ref_ang = '0; latch_ang = '0;
        quad_sum = '0; index_sum = '0; correction = '0;
        count_at_index = '0; last_latch = '0;
        locked = 0; mismatch_hold = 0;
        for (int i = 0; i < HIST; i++)
            history[i] = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: field extremes, small jumps below the threshold, wraps
        pending_samples.push_back({16'h0000, 16'h0000});
        pending_samples.push_back({16'h0005, 16'hFFFF});
        pending_samples.push_back({16'h7FFF, 16'h8000});
        pending_samples.push_back({16'hFFFF, 16'h7FFF});
        pending_samples.push_back({16'h8000, 16'h0001});
        pending_samples.push_back({16'hAAAA, 16'h5555});
        pending_samples.push_back({16'h5555, 16'hAAAA});
        for (int k = 0; k < 8; k++)
            pending_samples.push_back({16'(16'h5555 + 8000 * (k + 1) + k - 4),
                                       16'(k * 1000)});
        prev_quad_shadow = 16'(7000);
        prev_index_shadow = 16'(16'h5555 + 8000 * 8 + 3);
        drain();

        // Extremes of the configuration, including zero divisors
        write_reg(eidc_pkg::REG_COUNTS_PER_REV, 32'd4);
        write_reg(eidc_pkg::REG_POLE_PAIRS, 32'd64);
        write_reg(eidc_pkg::REG_INDEX_JUMP_MIN, 32'd0);
        write_reg(eidc_pkg::REG_REV_TOLERANCE, 32'd1023);
        write_reg(eidc_pkg::REG_MISSING_INDEX_REVS, 32'd1);
        write_reg(eidc_pkg::REG_TEST_OFFSET, 32'h8000_0000);
        queue_motion(40, 4);
        drain();
        write_reg(eidc_pkg::REG_COUNTS_PER_REV, 32'd0);
        write_reg(eidc_pkg::REG_POLE_PAIRS, 32'd0);
        write_reg(eidc_pkg::REG_TEST_OFFSET, 32'h7FFF_FFFF);
        queue_motion(20, 2);
        drain();
        write_reg(eidc_pkg::REG_COUNTS_PER_REV, 32'd1048576);
        write_reg(eidc_pkg::REG_POLE_PAIRS, 32'd1);
        write_reg(eidc_pkg::REG_INDEX_JUMP_MIN, 32'd1023);
        write_reg(eidc_pkg::REG_REV_TOLERANCE, 32'd0);
        write_reg(eidc_pkg::REG_MISSING_INDEX_REVS, 32'd15);
        queue_motion(30, 30000);
        drain();

        // Random phases with realistic revolutions
        for (int ph = 0; ph < 6; ph++)
        begin
            rev = $urandom_range(4000, 100);
            write_reg(eidc_pkg::REG_COUNTS_PER_REV, rev + $urandom_range(6) - 3);
            write_reg(eidc_pkg::REG_POLE_PAIRS, $urandom_range(64, 1));
            write_reg(eidc_pkg::REG_INDEX_JUMP_MIN, $urandom_range(60));
            write_reg(eidc_pkg::REG_REV_TOLERANCE, $urandom_range(20));
            write_reg(eidc_pkg::REG_MISSING_INDEX_REVS, $urandom_range(15, 1));
            write_reg(eidc_pkg::REG_TEST_OFFSET, (ph % 2) ? $urandom : $urandom_range(200));
            no_idle = (ph == 2);
            if (ph == 4)
            begin
                // Hold the receiver off so the block fills and stalls its input
                queue_motion(120, rev);
                rx_hold = 1;
                repeat (1500) @(posedge clk);
                rx_hold = 0;
            end
            else
                queue_motion(120, rev);
            drain();
        end
        if (failures == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire

// File: sim.f
+incdir+rtl
rtl/eidc_pkg.sv
rtl/eidc_divider.sv
rtl/encoder_index_drift_corrector.sv
tb/tb_encoder_index_drift_corrector.sv
